// ===== design/kei_pkg.sv =====
package kei_pkg;

    // Fixed-point format of time, control points and the curve
    localparam int FRAC_BITS  = 16;
    localparam int W_TIME     = 18;
    localparam int W_VAL      = 32;
    localparam int W_POLY     = 22;
    localparam int W_T        = 21;
    localparam int W_ACC      = 32;
    localparam int W_ERR      = 33;
    localparam int W_MA       = 34;
    localparam int W_MB       = 24;
    localparam int W_MRES     = 43;
    localparam int W_SUM      = 44;
    localparam int W_DIVN     = 50;
    localparam int W_UPD      = 52;
    localparam int W_CFG_IDX  = 3;
    localparam int W_MODE     = 3;
    localparam int W_IN_DATA  = 88;
    localparam int NEWTON_STEPS_DEF = 8;

    localparam logic [W_T-1:0] ONE_Q   = W_T'(1 << FRAC_BITS);
    localparam logic [W_T-1:0] T_LIMIT = W_T'(8 << FRAC_BITS);
    localparam int X_TOL       = ((1 << FRAC_BITS) + 500) / 1000;
    localparam int D_TOL_RAW   = ((1 << FRAC_BITS) + 500000) / 1000000;
    localparam int D_TOL       = (D_TOL_RAW > 0) ? D_TOL_RAW : 1;
    localparam int EASE_IN_X1  = (42 * (1 << FRAC_BITS) + 50) / 100;
    localparam int EASE_OUT_X2 = (58 * (1 << FRAC_BITS) + 50) / 100;

    // Easing modes
    localparam logic [W_MODE-1:0] MODE_LINEAR   = 3'd0;
    localparam logic [W_MODE-1:0] MODE_BEZIER   = 3'd1;
    localparam logic [W_MODE-1:0] MODE_EASE_IN  = 3'd2;
    localparam logic [W_MODE-1:0] MODE_EASE_OUT = 3'd3;
    localparam logic [W_MODE-1:0] MODE_HOLD     = 3'd4;

    // Configuration register indexes
    localparam logic [W_CFG_IDX-1:0] REG_MODE = 3'd0;
    localparam logic [W_CFG_IDX-1:0] REG_X1   = 3'd1;
    localparam logic [W_CFG_IDX-1:0] REG_Y1   = 3'd2;
    localparam logic [W_CFG_IDX-1:0] REG_X2   = 3'd3;
    localparam logic [W_CFG_IDX-1:0] REG_Y2   = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SX0, OP_SX1, OP_SX2, OP_D0, OP_D1, OP_DIVI,
        OP_DIVS, OP_UPD, OP_CLAMP, OP_SY0, OP_SY1, OP_SY2, OP_FIN
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHKI, ST_SX0, ST_SX1, ST_SX2, ST_CHKE, ST_D0, ST_D1,
        ST_CHKD, ST_DIVI, ST_DIVS, ST_UPD, ST_CLAMP, ST_SY0, ST_SY1, ST_SY2_FIN
    } t_state;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic iter;
        logic err_small;
        logic d_small;
        logic out_busy;
    } t_stat;

endpackage

// ===== design/keyframe_easing_interpolator_unit.sv =====
// Linear, hold and unused modes and Bezier end times need no iteration; Bezier runs
// Newton steps until the x error is within tolerance, the slope is flat, or all
// NEWTON_STEPS steps (eight by default) have run.
// Each Newton step is bound by the one-bit-per-cycle divider.
// One item is in flight at a time; the next is taken the cycle after the result is
// registered. Reset (i_rst_n low) loads the configuration defaults and idles the unit.
module keyframe_easing_interpolator_unit #(
    parameter int NEWTON_STEPS = kei_pkg::NEWTON_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [17:0] time_in, [49:18] start_val, [81:50] end_val, [87:82] zero
    input  logic [kei_pkg::W_IN_DATA-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] interp_val
    output logic [kei_pkg::W_VAL-1:0]     m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kei_pkg::W_CFG_IDX-1:0] i_cfg_index,
    input  logic [kei_pkg::W_TIME-1:0]    i_cfg_data
);
    import kei_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    kei_ctrl #(
        .NEWTON_STEPS(NEWTON_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    kei_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== design/kei_ctrl.sv =====
module kei_ctrl #(
    parameter int NEWTON_STEPS = kei_pkg::NEWTON_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  kei_pkg::t_stat i_stat,
    output kei_pkg::t_cmd  o_cmd
);
    import kei_pkg::*;

    localparam int W_STEP = $clog2(NEWTON_STEPS + 1);
    localparam int W_CNT  = $clog2(W_DIVN + 1);

    t_state             r_state, n_state;
    logic [W_STEP-1:0]  r_step, n_step;
    logic [W_CNT-1:0]   r_cnt, n_cnt;

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_cnt      = r_cnt;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_CHKI;
                end
            end
            ST_CHKI: begin
                n_step  = '0;
                n_state = i_stat.iter ? ST_SX0 : ST_SY2_FIN;
            end
            ST_SX0: begin
                o_cmd.op = OP_SX0;
                n_state  = ST_SX1;
            end
            ST_SX1: begin
                o_cmd.op = OP_SX1;
                n_state  = ST_SX2;
            end
            ST_SX2: begin
                o_cmd.op = OP_SX2;
                n_state  = ST_CHKE;
            end
            ST_CHKE: begin
                n_state = i_stat.err_small ? ST_CLAMP : ST_D0;
            end
            ST_D0: begin
                o_cmd.op = OP_D0;
                n_state  = ST_D1;
            end
            ST_D1: begin
                o_cmd.op = OP_D1;
                n_state  = ST_CHKD;
            end
            ST_CHKD: begin
                n_state = i_stat.d_small ? ST_CLAMP : ST_DIVI;
            end
            ST_DIVI: begin
                o_cmd.op = OP_DIVI;
                n_cnt    = '0;
                n_state  = ST_DIVS;
            end
            ST_DIVS: begin
                o_cmd.op = OP_DIVS;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == W_CNT'(W_DIVN - 1)) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.op = OP_UPD;
                n_step   = r_step + 1'b1;
                n_state  = (r_step == W_STEP'(NEWTON_STEPS - 1)) ? ST_CLAMP : ST_SX0;
            end
            ST_CLAMP: begin
                // counter marks whether the last y stage has run
                o_cmd.op = OP_CLAMP;
                n_cnt    = '0;
                n_state  = ST_SY0;
            end
            ST_SY0: begin
                o_cmd.op = OP_SY0;
                n_state  = ST_SY1;
            end
            ST_SY1: begin
                o_cmd.op = OP_SY1;
                n_state  = ST_SY2_FIN;
            end
            ST_SY2_FIN: begin
                // progress ready in acc once SY2 ran; iterative path runs SY2 first
                if (i_stat.iter && r_cnt != '1) begin
                    o_cmd.op = OP_SY2;
                    n_cnt    = '1;
                end else if (!i_stat.out_busy) begin
                    o_cmd.op = OP_FIN;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== design/kei_dp.sv =====
module kei_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kei_pkg::t_cmd                 i_cmd,
    output kei_pkg::t_stat                o_stat,
    input  logic [kei_pkg::W_IN_DATA-1:0] i_in_data,
    input  logic                          i_cfg_we,
    input  logic [kei_pkg::W_CFG_IDX-1:0] i_cfg_index,
    input  logic [kei_pkg::W_TIME-1:0]    i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [kei_pkg::W_VAL-1:0]     o_out_data
);
    import kei_pkg::*;

    // Configuration
    logic [W_MODE-1:0]        r_mode;
    logic signed [W_TIME-1:0] r_x1, r_y1, r_x2, r_y2;

    // Working registers
    logic signed [W_POLY-1:0] r_ax, r_bx, r_cx, r_ay, r_by, r_cy;
    logic signed [W_T-1:0]    r_t;
    logic [FRAC_BITS:0]       r_time;
    logic signed [W_ACC-1:0]  r_acc;
    logic signed [W_ERR-1:0]  r_err;
    logic signed [W_ACC-1:0]  r_d;
    logic signed [W_VAL-1:0]  r_sv;
    logic signed [W_ERR-1:0]  r_diff;
    logic                     r_iter;
    logic [W_DIVN-1:0]        r_num;
    logic [W_ACC-1:0]         r_rem;
    logic [W_ACC-1:0]         r_dm;
    logic                     r_qneg;
    logic                     r_out_valid;
    logic [W_VAL-1:0]         r_out;

    // Input unpack and time clamp
    logic signed [W_TIME-1:0] in_time;
    logic signed [W_VAL-1:0]  in_sv, in_ev;
    logic [FRAC_BITS:0]       time_c;
    assign in_time = i_in_data[W_TIME-1:0];
    assign in_sv   = i_in_data[W_TIME +: W_VAL];
    assign in_ev   = i_in_data[W_TIME+W_VAL +: W_VAL];

    always_comb begin
        if (in_time[W_TIME-1]) begin
            time_c = '0;
        end else if (in_time > $signed(W_TIME'(ONE_Q))) begin
            time_c = (FRAC_BITS+1)'(ONE_Q);
        end else begin
            time_c = in_time[FRAC_BITS:0];
        end
    end

    // Control points by mode and curve coefficients
    logic signed [W_POLY-1:0] px1, py1, px2, py2;
    logic signed [W_POLY-1:0] cxn, bxn, axn, cyn, byn, ayn;
    logic                     is_bez;
    always_comb begin
        px1 = W_POLY'(r_x1);
        py1 = W_POLY'(r_y1);
        px2 = W_POLY'(r_x2);
        py2 = W_POLY'(r_y2);
        is_bez = 1'b0;
        case (r_mode)
            MODE_BEZIER: is_bez = 1'b1;
            MODE_EASE_IN: begin
                is_bez = 1'b1;
                px1 = W_POLY'(EASE_IN_X1);
                py1 = '0;
                px2 = W_POLY'(ONE_Q);
                py2 = W_POLY'(ONE_Q);
            end
            MODE_EASE_OUT: begin
                is_bez = 1'b1;
                px1 = '0;
                py1 = '0;
                px2 = W_POLY'(EASE_OUT_X2);
                py2 = W_POLY'(ONE_Q);
            end
            default: is_bez = 1'b0;
        endcase
        cxn = W_POLY'(3 * px1);
        bxn = W_POLY'(3 * (px2 - px1) - cxn);
        axn = $signed(W_POLY'(ONE_Q)) - cxn - bxn;
        cyn = W_POLY'(3 * py1);
        byn = W_POLY'(3 * (py2 - py1) - cyn);
        ayn = $signed(W_POLY'(ONE_Q)) - cyn - byn;
    end

    // Progress for the non-iterative cases
    logic [FRAC_BITS:0] prog0;
    always_comb begin
        if (r_mode == MODE_HOLD) begin
            prog0 = (time_c == (FRAC_BITS+1)'(ONE_Q)) ? time_c : '0;
        end else begin
            prog0 = time_c;
        end
    end

    // Shared rounding multiplier: mulq(a, b) + addend
    logic signed [W_MA-1:0]   mul_a;
    logic signed [W_MB-1:0]   mul_b;
    logic signed [W_SUM-1:0]  addend;
    logic [W_MA-1:0]          mag_a;
    logic [W_MB-1:0]          mag_b;
    logic [W_MA+W_MB-1:0]     prod;
    logic [W_MA+W_MB-1:0]     prod_r;
    logic [W_MRES-1:0]        rnd;
    logic signed [W_MRES-1:0] mres;
    logic signed [W_SUM-1:0]  sum;
    logic signed [W_MB-1:0]   t_ext;

    assign t_ext = W_MB'(r_t);
    always_comb begin
        mul_a  = W_MA'(r_acc);
        mul_b  = t_ext;
        addend = '0;
        case (i_cmd.op)
            OP_SX0: begin
                mul_a  = W_MA'(r_ax);
                addend = W_SUM'(r_bx);
            end
            OP_SX1, OP_D1: addend = W_SUM'(r_cx);
            OP_D0: begin
                mul_a  = W_MA'(3 * W_MA'(r_ax));
                addend = W_SUM'(2 * W_SUM'(r_bx));
            end
            OP_SY0: begin
                mul_a  = W_MA'(r_ay);
                addend = W_SUM'(r_by);
            end
            OP_SY1: addend = W_SUM'(r_cy);
            OP_FIN: begin
                mul_a  = W_MA'(r_diff);
                mul_b  = W_MB'(r_acc);
                addend = W_SUM'(r_sv);
            end
            default: addend = '0;
        endcase
        mag_a  = mul_a[W_MA-1] ? W_MA'(-mul_a) : W_MA'(mul_a);
        mag_b  = mul_b[W_MB-1] ? W_MB'(-mul_b) : W_MB'(mul_b);
        prod   = (W_MA+W_MB)'(mag_a) * (W_MA+W_MB)'(mag_b);
        prod_r = prod + (W_MA+W_MB)'(1 << (FRAC_BITS - 1));
        rnd    = W_MRES'(prod_r >> FRAC_BITS);
        mres   = (mul_a[W_MA-1] ^ mul_b[W_MB-1]) ? -$signed(rnd) : $signed(rnd);
        sum    = W_SUM'(mres) + addend;
    end

    // Divider step, Newton update, t clamp and result saturation
    logic [W_ACC:0]          div_sh;
    logic                    div_ge;
    logic [W_ERR-1:0]        err_mag;
    logic [W_ACC-1:0]        d_mag;
    logic signed [W_UPD-1:0] q_s, t_new;
    logic signed [W_T-1:0]   t_sat, t_clamp;
    logic signed [W_VAL-1:0] res_sat;

    assign div_sh  = {r_rem, r_num[W_DIVN-1]};
    assign div_ge  = div_sh >= {1'b0, r_dm};
    assign err_mag = r_err[W_ERR-1] ? W_ERR'(-r_err) : W_ERR'(r_err);
    assign d_mag   = r_d[W_ACC-1] ? W_ACC'(-r_d) : W_ACC'(r_d);

    always_comb begin
        q_s   = r_qneg ? -$signed(W_UPD'(r_num)) : $signed(W_UPD'(r_num));
        t_new = W_UPD'(r_t) - q_s;
        if (t_new > $signed(W_UPD'(T_LIMIT))) begin
            t_sat = $signed(T_LIMIT);
        end else if (t_new < -$signed(W_UPD'(T_LIMIT))) begin
            t_sat = -$signed(T_LIMIT);
        end else begin
            t_sat = W_T'(t_new);
        end
        if (r_t[W_T-1]) begin
            t_clamp = '0;
        end else if (r_t > $signed(ONE_Q)) begin
            t_clamp = $signed(ONE_Q);
        end else begin
            t_clamp = r_t;
        end
        if (sum > $signed(W_SUM'(32'sh7fffffff))) begin
            res_sat = 32'sh7fffffff;
        end else if (sum < -$signed(W_SUM'(33'h080000000))) begin
            res_sat = 32'sh80000000;
        end else begin
            res_sat = W_VAL'(sum);
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LINEAR;
            r_x1   <= '0;
            r_y1   <= '0;
            r_x2   <= W_TIME'(ONE_Q);
            r_y2   <= W_TIME'(ONE_Q);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE: r_mode <= i_cfg_data[W_MODE-1:0];
                REG_X1:   r_x1   <= i_cfg_data;
                REG_Y1:   r_y1   <= i_cfg_data;
                REG_X2:   r_x2   <= i_cfg_data;
                REG_Y2:   r_y2   <= i_cfg_data;
                default:  r_mode <= r_mode;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_FIN) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Iteration flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= 1'b0;
        end else if (i_cmd.op == OP_LOAD) begin
            r_iter <= is_bez && (time_c != '0) && (time_c != (FRAC_BITS+1)'(ONE_Q));
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_time <= time_c;
                r_t    <= W_T'(time_c);
                r_acc  <= W_ACC'(prog0);
                r_sv   <= in_sv;
                r_diff <= W_ERR'(in_ev) - W_ERR'(in_sv);
                r_ax   <= axn;
                r_bx   <= bxn;
                r_cx   <= cxn;
                r_ay   <= ayn;
                r_by   <= byn;
                r_cy   <= cyn;
            end
            OP_SX0, OP_SX1, OP_D0, OP_SY0, OP_SY1, OP_SY2: r_acc <= W_ACC'(sum);
            OP_SX2: r_err <= W_ERR'(sum) - W_ERR'(r_time);
            OP_D1:  r_d   <= W_ACC'(sum);
            OP_DIVI: begin
                r_num  <= (W_DIVN'(err_mag) << FRAC_BITS) + W_DIVN'(d_mag >> 1);
                r_rem  <= '0;
                r_dm   <= d_mag;
                r_qneg <= r_err[W_ERR-1] ^ r_d[W_ACC-1];
            end
            OP_DIVS: begin
                r_rem <= div_ge ? W_ACC'(div_sh - {1'b0, r_dm}) : W_ACC'(div_sh);
                r_num <= {r_num[W_DIVN-2:0], div_ge};
            end
            OP_UPD:   r_t   <= t_sat;
            OP_CLAMP: r_t   <= t_clamp;
            OP_FIN:   r_out <= res_sat;
            default:  r_t   <= r_t;
        endcase
    end

    assign o_stat.iter      = r_iter;
    assign o_stat.err_small = err_mag < W_ERR'(X_TOL);
    assign o_stat.d_small   = d_mag < W_ACC'(D_TOL);
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

endmodule
